// ===== hw/rtl/dafp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_pkg
// Types, constants and fitting helpers shared by the torsion angle pipeline.
// ----------------------------------------------------------------------------
package dafp_pkg;

    localparam int FIT_BITS        = 30;
    localparam int FIT_W           = FIT_BITS + 1;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STEPS    = 30;
    localparam int ISQRT_STEPS     = 32;

    typedef logic signed [FIT_W-1:0] fit_t;
    typedef logic signed [61:0]      prod_t;
    typedef logic signed [33:0]      rot_t;

    localparam rot_t PI_Q30      = 34'sd3373259426;
    localparam rot_t HALF_PI_Q30 = 34'sd1686629713;
    localparam rot_t ROUND_HALF  = 34'sd1 <<< (29 - ANGLE_FRAC_BITS);
    localparam rot_t PI_ROUNDED  = (PI_Q30 + ROUND_HALF) >>> (30 - ANGLE_FRAC_BITS);
    localparam logic signed [15:0] TORSION_MAX = PI_ROUNDED[15:0];

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    typedef struct packed {
        fit_t x;
        fit_t y;
        fit_t z;
    } vec_t;

    typedef struct packed {
        vec_t       v;
        logic [5:0] sh;
    } fitv_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [61:0] x;
        logic signed [61:0] y;
        logic signed [61:0] z;
    } mvec_t;

    typedef struct packed {
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p1_z;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p2_z;
        logic signed [31:0] p3_x;
        logic signed [31:0] p3_y;
        logic signed [31:0] p3_z;
        logic signed [31:0] p4_x;
        logic signed [31:0] p4_y;
        logic signed [31:0] p4_z;
    } pts_t;

    typedef struct packed {
        fit_t             xm;
        logic [5:0]       ex;
        logic [FIT_W-1:0] ym;
        logic [5:0]       ey;
        logic [5:0]       sn;
        logic             ypos;
        logic             degen;
    } side_t;

    // two's complement bits needed to hold v
    function automatic logic [6:0] sig_bits(input logic signed [63:0] v);
        logic [6:0] n;
        n = 7'd1;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i] != v[63])
            begin
                n = 7'(i + 2);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] fit_shift(input logic signed [63:0] v);
        logic [6:0] sb;
        sb = sig_bits(v);
        if (sb > 7'(FIT_W))
        begin
            return 6'(sb - 7'(FIT_W));
        end
        return 6'd0;
    endfunction

    function automatic fit_t fit_apply(input logic signed [63:0] v, input logic [5:0] k);
        logic signed [63:0] s;
        s = v >>> k;
        return s[FIT_W-1:0];
    endfunction

    function automatic logic [5:0] max_sh(input logic [5:0] a, input logic [5:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic fitv_t fit3(input logic signed [63:0] a,
                                   input logic signed [63:0] b,
                                   input logic signed [63:0] c);
        fitv_t      r;
        logic [5:0] k;
        k     = max_sh(max_sh(fit_shift(a), fit_shift(b)), fit_shift(c));
        r.sh  = k;
        r.v.x = fit_apply(a, k);
        r.v.y = fit_apply(b, k);
        r.v.z = fit_apply(c, k);
        return r;
    endfunction

endpackage

// ===== hw/rtl/dafp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_in_if
// Input channel: four points per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dafp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic signed [31:0] p3_z;
    logic signed [31:0] p4_x;
    logic signed [31:0] p4_y;
    logic signed [31:0] p4_z;

    modport source (
        output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
               p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
        input  ready
    );
    modport sink (
        input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
               p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
        output ready
    );
endinterface

// ===== hw/rtl/dafp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_out_if
// Result channel: torsion angle and degenerate flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dafp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] torsion;
    logic               degenerate;

    modport source (
        output valid, torsion, degenerate,
        input  ready
    );
    modport sink (
        input  valid, torsion, degenerate,
        output ready
    );
endinterface

// ===== hw/rtl/dihedral_angle_from_four_points.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points
// Torsion angle about the p2-p3 axis from four Q16.16 points, Q2.13 radians.
//
//   channel   role   payload
//   points    sink   p1_x .. p4_z, signed 32 bit each
//   result    source torsion (signed 16 bit), degenerate (1 bit)
//
// one item per cycle in, one result per cycle out unless the output stalls;
// the path has 11 vector stages, 32 square root stages, 3 scaling stages,
// 30 rotator stages and the output register
// rst_n clears all valid bits; data registers are not reset
// a result held at the output freezes every stage; nothing is lost or repeated
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points (
    input  logic       clk,
    input  logic       rst_n,
    dafp_in_if.sink    points,
    dafp_out_if.source result
);

    logic                       en;
    dafp_pkg::pts_t             pts;
    logic                       fr_valid;
    logic [61:0]                fr_dsq;
    dafp_pkg::side_t            fr_side;
    logic                       sq_valid;
    logic [dafp_pkg::FIT_W-1:0] sq_root;
    dafp_pkg::side_t            sq_side;

    assign en            = !result.valid || result.ready;
    assign points.ready  = en;

    assign pts.p1_x = points.p1_x;
    assign pts.p1_y = points.p1_y;
    assign pts.p1_z = points.p1_z;
    assign pts.p2_x = points.p2_x;
    assign pts.p2_y = points.p2_y;
    assign pts.p2_z = points.p2_z;
    assign pts.p3_x = points.p3_x;
    assign pts.p3_y = points.p3_y;
    assign pts.p3_z = points.p3_z;
    assign pts.p4_x = points.p4_x;
    assign pts.p4_y = points.p4_y;
    assign pts.p4_z = points.p4_z;

    dafp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (points.valid),
        .pts       (pts),
        .out_valid (fr_valid),
        .dsq       (fr_dsq),
        .side      (fr_side)
    );

    dafp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .radicand  (fr_dsq),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    dafp_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .root       (sq_root),
        .side       (sq_side),
        .out_valid  (result.valid),
        .torsion    (result.torsion),
        .degenerate (result.degenerate)
    );

endmodule

// ===== hw/rtl/dafp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_front
// Eleven stage vector front end: bond vectors, cross and dot products,
// fitting, axis length squared and the sine/cosine terms of the angle.
// ----------------------------------------------------------------------------
module dafp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  dafp_pkg::pts_t       pts,
    output logic                 out_valid,
    output logic [61:0]          dsq,
    output dafp_pkg::side_t      side
);

    localparam int NSTG = 11;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // stage 1
    dafp_pkg::dvec_t d1_reg, d2_reg, d3_reg;
    // stage 2
    dafp_pkg::vec_t  f1_reg, f2_reg, f3_reg;
    // stage 3
    dafp_pkg::prod_t cp_reg [12];
    dafp_pkg::prod_t sq_reg [3];
    dafp_pkg::vec_t  d2c3_reg;
    logic            d2zero_reg;
    // stage 4
    dafp_pkg::mvec_t m1_reg, m3_reg;
    logic [61:0]     dsq4_reg;
    dafp_pkg::vec_t  d2c4_reg;
    logic            degen4_reg;
    // stage 5
    dafp_pkg::vec_t  m1f_reg, m3f_reg;
    logic [61:0]     dsq5_reg;
    dafp_pkg::vec_t  d2c5_reg;
    logic            degen5_reg;
    // stage 6
    dafp_pkg::prod_t xp_reg [3];
    dafp_pkg::prod_t np_reg [6];
    logic [61:0]     dsq6_reg;
    dafp_pkg::vec_t  d2c6_reg;
    logic            degen6_reg;
    // stage 7
    logic signed [62:0] xs_reg;
    dafp_pkg::mvec_t    n_reg;
    logic [61:0]        dsq7_reg;
    dafp_pkg::vec_t     d2c7_reg;
    logic               degen7_reg;
    // stage 8
    dafp_pkg::vec_t  nf_reg;
    logic [5:0]      sn8_reg;
    dafp_pkg::fit_t  xm8_reg;
    logic [5:0]      ex8_reg;
    logic [61:0]     dsq8_reg;
    dafp_pkg::vec_t  d2c8_reg;
    logic            degen8_reg;
    // stage 9
    dafp_pkg::prod_t yp_reg [3];
    logic [5:0]      sn9_reg;
    dafp_pkg::fit_t  xm9_reg;
    logic [5:0]      ex9_reg;
    logic [61:0]     dsq9_reg;
    logic            degen9_reg;
    // stage 10
    logic [61:0]     ym10_reg;
    logic            ypos10_reg;
    logic [5:0]      sn10_reg;
    dafp_pkg::fit_t  xm10_reg;
    logic [5:0]      ex10_reg;
    logic [61:0]     dsq10_reg;
    logic            degen10_reg;
    // stage 11
    dafp_pkg::side_t side_reg;
    logic [61:0]     dsq11_reg;

    dafp_pkg::fitv_t    fa, fb, fc, fm1, fm3, fn;
    logic signed [62:0] yr;
    logic signed [62:0] yabs;
    logic [5:0]         kx, ky;

    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        fa  = dafp_pkg::fit3(64'(d1_reg.x), 64'(d1_reg.y), 64'(d1_reg.z));
        fb  = dafp_pkg::fit3(64'(d2_reg.x), 64'(d2_reg.y), 64'(d2_reg.z));
        fc  = dafp_pkg::fit3(64'(d3_reg.x), 64'(d3_reg.y), 64'(d3_reg.z));
        fm1 = dafp_pkg::fit3(64'(m1_reg.x), 64'(m1_reg.y), 64'(m1_reg.z));
        fm3 = dafp_pkg::fit3(64'(m3_reg.x), 64'(m3_reg.y), 64'(m3_reg.z));
        fn  = dafp_pkg::fit3(64'(n_reg.x), 64'(n_reg.y), 64'(n_reg.z));
        kx  = dafp_pkg::fit_shift(64'(xs_reg));
        yr  = 63'(yp_reg[0]) + 63'(yp_reg[1]) + 63'(yp_reg[2]);
        yabs = (yr < 0) ? -yr : yr;
        ky  = dafp_pkg::fit_shift(64'(ym10_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: bond vectors
            d1_reg.x <= 33'(pts.p1_x) - 33'(pts.p2_x);
            d1_reg.y <= 33'(pts.p1_y) - 33'(pts.p2_y);
            d1_reg.z <= 33'(pts.p1_z) - 33'(pts.p2_z);
            d2_reg.x <= 33'(pts.p3_x) - 33'(pts.p2_x);
            d2_reg.y <= 33'(pts.p3_y) - 33'(pts.p2_y);
            d2_reg.z <= 33'(pts.p3_z) - 33'(pts.p2_z);
            d3_reg.x <= 33'(pts.p4_x) - 33'(pts.p3_x);
            d3_reg.y <= 33'(pts.p4_y) - 33'(pts.p3_y);
            d3_reg.z <= 33'(pts.p4_z) - 33'(pts.p3_z);

            // stage 2: fit
            f1_reg <= fa.v;
            f2_reg <= fb.v;
            f3_reg <= fc.v;

            // stage 3: cross product terms and axis squares
            cp_reg[0]  <= f1_reg.y * f2_reg.z;
            cp_reg[1]  <= f1_reg.z * f2_reg.y;
            cp_reg[2]  <= f1_reg.z * f2_reg.x;
            cp_reg[3]  <= f1_reg.x * f2_reg.z;
            cp_reg[4]  <= f1_reg.x * f2_reg.y;
            cp_reg[5]  <= f1_reg.y * f2_reg.x;
            cp_reg[6]  <= f3_reg.y * f2_reg.z;
            cp_reg[7]  <= f3_reg.z * f2_reg.y;
            cp_reg[8]  <= f3_reg.z * f2_reg.x;
            cp_reg[9]  <= f3_reg.x * f2_reg.z;
            cp_reg[10] <= f3_reg.x * f2_reg.y;
            cp_reg[11] <= f3_reg.y * f2_reg.x;
            sq_reg[0]  <= f2_reg.x * f2_reg.x;
            sq_reg[1]  <= f2_reg.y * f2_reg.y;
            sq_reg[2]  <= f2_reg.z * f2_reg.z;
            d2c3_reg   <= f2_reg;
            d2zero_reg <= (f2_reg == '0);

            // stage 4: cross products, degenerate test
            m1_reg.x   <= 62'(cp_reg[0]) - 62'(cp_reg[1]);
            m1_reg.y   <= 62'(cp_reg[2]) - 62'(cp_reg[3]);
            m1_reg.z   <= 62'(cp_reg[4]) - 62'(cp_reg[5]);
            m3_reg.x   <= 62'(cp_reg[6]) - 62'(cp_reg[7]);
            m3_reg.y   <= 62'(cp_reg[8]) - 62'(cp_reg[9]);
            m3_reg.z   <= 62'(cp_reg[10]) - 62'(cp_reg[11]);
            dsq4_reg   <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            d2c4_reg   <= d2c3_reg;
            degen4_reg <= d2zero_reg
                        || ((cp_reg[0] == cp_reg[1]) && (cp_reg[2] == cp_reg[3])
                            && (cp_reg[4] == cp_reg[5]))
                        || ((cp_reg[6] == cp_reg[7]) && (cp_reg[8] == cp_reg[9])
                            && (cp_reg[10] == cp_reg[11]));

            // stage 5: fit normals
            m1f_reg    <= fm1.v;
            m3f_reg    <= fm3.v;
            dsq5_reg   <= dsq4_reg;
            d2c5_reg   <= d2c4_reg;
            degen5_reg <= degen4_reg;

            // stage 6: cosine terms and n = m3 x m1 terms
            xp_reg[0]  <= m1f_reg.x * m3f_reg.x;
            xp_reg[1]  <= m1f_reg.y * m3f_reg.y;
            xp_reg[2]  <= m1f_reg.z * m3f_reg.z;
            np_reg[0]  <= m3f_reg.y * m1f_reg.z;
            np_reg[1]  <= m3f_reg.z * m1f_reg.y;
            np_reg[2]  <= m3f_reg.z * m1f_reg.x;
            np_reg[3]  <= m3f_reg.x * m1f_reg.z;
            np_reg[4]  <= m3f_reg.x * m1f_reg.y;
            np_reg[5]  <= m3f_reg.y * m1f_reg.x;
            dsq6_reg   <= dsq5_reg;
            d2c6_reg   <= d2c5_reg;
            degen6_reg <= degen5_reg;

            // stage 7
            xs_reg     <= 63'(xp_reg[0]) + 63'(xp_reg[1]) + 63'(xp_reg[2]);
            n_reg.x    <= 62'(np_reg[0]) - 62'(np_reg[1]);
            n_reg.y    <= 62'(np_reg[2]) - 62'(np_reg[3]);
            n_reg.z    <= 62'(np_reg[4]) - 62'(np_reg[5]);
            dsq7_reg   <= dsq6_reg;
            d2c7_reg   <= d2c6_reg;
            degen7_reg <= degen6_reg;

            // stage 8: fit n and cosine term
            nf_reg     <= fn.v;
            sn8_reg    <= fn.sh;
            xm8_reg    <= dafp_pkg::fit_apply(64'(xs_reg), kx);
            ex8_reg    <= kx;
            dsq8_reg   <= dsq7_reg;
            d2c8_reg   <= d2c7_reg;
            degen8_reg <= degen7_reg;

            // stage 9: sine terms
            yp_reg[0]  <= nf_reg.x * d2c8_reg.x;
            yp_reg[1]  <= nf_reg.y * d2c8_reg.y;
            yp_reg[2]  <= nf_reg.z * d2c8_reg.z;
            sn9_reg    <= sn8_reg;
            xm9_reg    <= xm8_reg;
            ex9_reg    <= ex8_reg;
            dsq9_reg   <= dsq8_reg;
            degen9_reg <= degen8_reg;

            // stage 10
            ym10_reg    <= yabs[61:0];
            ypos10_reg  <= (yr > 0);
            sn10_reg    <= sn9_reg;
            xm10_reg    <= xm9_reg;
            ex10_reg    <= ex9_reg;
            dsq10_reg   <= dsq9_reg;
            degen10_reg <= degen9_reg;

            // stage 11: fit sine magnitude
            side_reg.xm    <= xm10_reg;
            side_reg.ex    <= ex10_reg;
            side_reg.ym    <= dafp_pkg::fit_apply(64'(ym10_reg), ky);
            side_reg.ey    <= ky;
            side_reg.sn    <= sn10_reg;
            side_reg.ypos  <= ypos10_reg;
            side_reg.degen <= degen10_reg;
            dsq11_reg      <= dsq10_reg;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign dsq       = dsq11_reg;
    assign side      = side_reg;

endmodule

// ===== hw/rtl/dafp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_isqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module dafp_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [61:0]                 radicand,
    input  dafp_pkg::side_t             in_side,
    output logic                        out_valid,
    output logic [dafp_pkg::FIT_W-1:0]  root,
    output dafp_pkg::side_t             out_side
);

    localparam int N = dafp_pkg::ISQRT_STEPS;

    logic [N-1:0]    vld_reg;
    logic [N-1:0]    vld_next;
    logic [63:0]     v_reg    [N];
    logic [63:0]     r_reg    [N];
    dafp_pkg::side_t side_reg [N];

    assign vld_next = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]     v_in;
        logic [63:0]     r_in;
        logic [63:0]     trial;
        dafp_pkg::side_t s_in;

        if (k == 0)
        begin : g_first
            assign v_in = 64'(radicand);
            assign r_in = '0;
            assign s_in = in_side;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    v_reg[k] <= v_in - trial;
                    r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    v_reg[k] <= v_in;
                    r_reg[k] <= r_in >> 1;
                end
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = r_reg[N-1][dafp_pkg::FIT_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hw/rtl/dafp_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_angle
// Scales cosine and sine terms to a common exponent, runs a 30 stage
// vectoring rotator and rounds, signs and registers the angle.
// ----------------------------------------------------------------------------
module dafp_angle (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dafp_pkg::FIT_W-1:0]  root,
    input  dafp_pkg::side_t             side,
    output logic                        out_valid,
    output logic signed [15:0]          torsion,
    output logic                        degenerate
);

    localparam int NC   = dafp_pkg::CORDIC_STEPS;
    localparam int NSTG = NC + 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // stage a1
    logic signed [62:0]         a1_reg;
    logic [dafp_pkg::FIT_W-1:0] b1_reg;
    logic [5:0]                 ea1_reg;
    logic [6:0]                 eb1_reg;
    logic                       ypos1_reg, degen1_reg;
    // stage a2
    logic signed [62:0]         a2_reg;
    logic [dafp_pkg::FIT_W-1:0] b2_reg;
    logic                       ypos2_reg, degen2_reg;
    // rotator
    dafp_pkg::rot_t             x_reg    [NC + 1];
    dafp_pkg::rot_t             y_reg    [NC + 1];
    dafp_pkg::rot_t             z_reg    [NC + 1];
    logic                       ypos_reg [NC + 1];
    logic                       dgn_reg  [NC + 1];
    // output
    logic signed [15:0]         torsion_reg;
    logic                       degen_reg;

    logic [6:0]         ea7, dd;
    logic [5:0]         shc;
    logic               a_big;
    logic [5:0]         kp;
    dafp_pkg::fit_t     xf, yf;
    dafp_pkg::rot_t     zc, rr;
    logic signed [15:0] rsg;

    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        ea7   = 7'(ea1_reg);
        a_big = (ea7 > eb1_reg);
        dd    = a_big ? (ea7 - eb1_reg) : (eb1_reg - ea7);
        shc   = (dd > 7'd63) ? 6'd63 : dd[5:0];
        kp    = dafp_pkg::max_sh(dafp_pkg::fit_shift(64'(a2_reg)),
                                 dafp_pkg::fit_shift(64'(b2_reg)));
        xf    = dafp_pkg::fit_apply(64'(a2_reg), kp);
        yf    = dafp_pkg::fit_apply(64'(b2_reg), kp);
        zc    = z_reg[NC];
        if (zc < 0)
        begin
            zc = '0;
        end
        else if (zc > dafp_pkg::PI_Q30)
        begin
            zc = dafp_pkg::PI_Q30;
        end
        rr    = (zc + dafp_pkg::ROUND_HALF) >>> (30 - dafp_pkg::ANGLE_FRAC_BITS);
        rsg   = ypos_reg[NC] ? -rr[15:0] : rr[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a1: cosine term times axis length, exponents
            a1_reg     <= side.xm * $signed({1'b0, root});
            b1_reg     <= side.ym;
            ea1_reg    <= side.ex;
            eb1_reg    <= 7'(side.ey) + 7'(side.sn);
            ypos1_reg  <= side.ypos;
            degen1_reg <= side.degen;

            // a2: align to the larger exponent
            a2_reg     <= a_big ? a1_reg : (a1_reg >>> shc);
            b2_reg     <= a_big ? (b1_reg >> shc) : b1_reg;
            ypos2_reg  <= ypos1_reg;
            degen2_reg <= degen1_reg;

            // a3: fit pair, fold left half plane
            if (xf < 0)
            begin
                x_reg[0] <= 34'(yf);
                y_reg[0] <= -34'(xf);
                z_reg[0] <= dafp_pkg::HALF_PI_Q30;
            end
            else
            begin
                x_reg[0] <= 34'(xf);
                y_reg[0] <= 34'(yf);
                z_reg[0] <= '0;
            end
            ypos_reg[0] <= ypos2_reg;
            dgn_reg[0]  <= degen2_reg;

            // output register
            torsion_reg <= dgn_reg[NC] ? '0 : rsg;
            degen_reg   <= dgn_reg[NC];
        end
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_rot
        localparam dafp_pkg::rot_t ANG = $signed({4'b0, dafp_pkg::ATAN_Q30[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                ypos_reg[i+1] <= ypos_reg[i];
                dgn_reg[i+1]  <= dgn_reg[i];
            end
        end
    end

    assign out_valid  = vld_reg[NSTG-1];
    assign torsion    = torsion_reg;
    assign degenerate = degen_reg;

endmodule

// ===== hw/rtl/dafp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dafp_checker
// Port level checks for the torsion angle block, bound to the top level.
// ----------------------------------------------------------------------------
module dafp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] torsion,
    input logic               degenerate
);

    default disable iff (!rst_n);

    a_hold: assert property (@(posedge clk)
        out_valid && !out_ready |=> out_valid && $stable(torsion) && $stable(degenerate))
        else $error("result changed while stalled");

    a_degen_zero: assert property (@(posedge clk)
        out_valid && degenerate |-> torsion == 16'sd0)
        else $error("degenerate item with nonzero angle");

    a_range: assert property (@(posedge clk)
        out_valid |-> (torsion >= -dafp_pkg::TORSION_MAX) && (torsion <= dafp_pkg::TORSION_MAX))
        else $error("angle out of range");

    a_empty_ready: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_stall_blocks: assert property (@(posedge clk)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken during output stall");

endmodule

bind dihedral_angle_from_four_points dafp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (points.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .torsion    (result.torsion),
    .degenerate (result.degenerate)
);

// ===== test/dihedral_angle_from_four_points_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points_chk
// Watches the point and result channels, computes the expected torsion angle
// and degenerate flag for every accepted item, and compares results in order.
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points_chk (
    input  logic       clk,
    input  logic       rst_n,
    dafp_in_if.sink    points,
    dafp_out_if.sink   result,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic signed [15:0] torsion;
        logic               degenerate;
    } angle_t;

    localparam longint LIM = 64'sd1 << 30;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;

    angle_t angle_q[$];

    function automatic longint fshr(input longint v, input int k);
        if (k > 63)
        begin
            k = 63;
        end
        if (k <= 0)
        begin
            return v;
        end
        return v >>> k;
    endfunction

    function automatic int fit_vec(inout longint v[3], input int cnt);
        int s;
        bit big;
        s = 0;
        forever
        begin
            big = 0;
            for (int i = 0; i < cnt; i++)
            begin
                if (v[i] >= LIM || v[i] < -LIM)
                begin
                    big = 1;
                end
            end
            if (!big)
            begin
                break;
            end
            for (int i = 0; i < cnt; i++)
            begin
                v[i] = v[i] >>> 1;
            end
            s++;
        end
        return s;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint dot3(input longint a[3], input longint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic angle_t torsion_of(input longint p[12]);
        longint d1[3], d2[3], d3[3], m1[3], m3[3], n[3], pr[3], one[3];
        longint xs, yr, ym, a, b, x, y, z, t, r, xn, yn;
        int sn, ex, ey, eb, dummy;
        bit ypos;
        angle_t res;
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = p[i] - p[3+i];
            d2[i] = p[6+i] - p[3+i];
            d3[i] = p[9+i] - p[6+i];
        end
        dummy = fit_vec(d1, 3);
        dummy = fit_vec(d2, 3);
        dummy = fit_vec(d3, 3);
        cross3(d1, d2, m1);
        cross3(d3, d2, m3);
        if ((d2[0] == 0 && d2[1] == 0 && d2[2] == 0) ||
            (m1[0] == 0 && m1[1] == 0 && m1[2] == 0) ||
            (m3[0] == 0 && m3[1] == 0 && m3[2] == 0))
        begin
            res.torsion = '0;
            res.degenerate = 1'b1;
            return res;
        end
        dummy = fit_vec(m1, 3);
        dummy = fit_vec(m3, 3);
        xs = dot3(m1, m3);
        cross3(m3, m1, n);
        sn = fit_vec(n, 3);
        yr = dot3(n, d2);
        ypos = yr > 0;
        ym = (yr < 0) ? -yr : yr;
        one = '{xs, 0, 0};
        ex = fit_vec(one, 1);
        a = one[0] * int_sqrt(longint'(dot3(d2, d2)));
        one = '{ym, 0, 0};
        ey = fit_vec(one, 1);
        b = one[0];
        eb = ey + sn;
        if (ex > eb)
        begin
            b = fshr(b, ex - eb);
        end
        else
        begin
            a = fshr(a, eb - ex);
        end
        pr = '{a, b, 0};
        dummy = fit_vec(pr, 2);
        x = pr[0];
        y = pr[1];
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Q;
        end
        for (int i = 0; i < dafp_pkg::CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z += longint'(dafp_pkg::ATAN_Q30[i]);
            end
            else
            begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z -= longint'(dafp_pkg::ATAN_Q30[i]);
            end
            x = xn;
            y = yn;
        end
        if (z < 0)
        begin
            z = 0;
        end
        if (z > PI_Q)
        begin
            z = PI_Q;
        end
        r = (z + (64'sd1 << (29 - dafp_pkg::ANGLE_FRAC_BITS)))
            >>> (30 - dafp_pkg::ANGLE_FRAC_BITS);
        if (ypos)
        begin
            r = -r;
        end
        res.torsion = r[15:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint p[12];
        angle_t got, want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (points.valid && points.ready)
            begin
                p = '{points.p1_x, points.p1_y, points.p1_z,
                      points.p2_x, points.p2_y, points.p2_z,
                      points.p3_x, points.p3_y, points.p3_z,
                      points.p4_x, points.p4_y, points.p4_z};
                angle_q.push_back(torsion_of(p));
            end
            if (result.valid && result.ready)
            begin
                got.torsion = result.torsion;
                got.degenerate = result.degenerate;
                if (angle_q.size() == 0)
                begin
                    $display("%0t: unexpected result torsion=%0d degenerate=%0b",
                             $time, got.torsion, got.degenerate);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch expected torsion=%0d degenerate=%0b,",
                                  " got torsion=%0d degenerate=%0b"},
                                 $time, want.torsion, want.degenerate,
                                 got.torsion, got.degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= angle_q.size();
        end
    end

endmodule

// ===== test/dihedral_angle_from_four_points_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points_tb
// Drives point items with random gaps and result stalls, including a long
// output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points_tb;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   n_sent;
    bit   hold_off;

    dafp_in_if  points ();
    dafp_out_if result ();

    dihedral_angle_from_four_points dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points.sink),
        .result (result.source)
    );

    dihedral_angle_from_four_points_chk checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .points     (points.sink),
        .result     (result.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 12;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(0, 20)) - 10);
        endcase
    endfunction

    task automatic send(input logic [31:0] c[12]);
        points.valid <= 1'b1;
        {points.p1_x, points.p1_y, points.p1_z, points.p2_x, points.p2_y,
         points.p2_z, points.p3_x, points.p3_y, points.p3_z, points.p4_x,
         points.p4_y, points.p4_z} <= {c[0], c[1], c[2], c[3], c[4], c[5],
                                      c[6], c[7], c[8], c[9], c[10], c[11]};
        @(posedge clk);
        while (!points.ready)
        begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    task automatic idle(input int g);
        if (g > 0)
        begin
            points.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // result side stalls
    initial
    begin
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            result.ready <= 1'b1;
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    result.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[dihedral_angle_from_four_points] ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] c[12];
        int mode, guard;
        n_sent = 0;
        hold_off = 0;
        rst_n = 1'b0;
        points.valid = 1'b0;
        {points.p1_x, points.p1_y, points.p1_z, points.p2_x, points.p2_y,
         points.p2_z, points.p3_x, points.p3_y, points.p3_z, points.p4_x,
         points.p4_y, points.p4_z} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, axis of zero length, points on the axis line,
        // exact 0 and pi, right angles of both signs
        c = '{default: 32'h0};
        send(c);
        c = '{default: 32'h7fffffff};
        send(c);
        c = '{default: 32'h80000000};
        send(c);
        c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7fffffff};
        send(c);
        c = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h80000000};
        send(c);
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000};
        send(c);
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 32'hffff0000, 0,
              32'h10000};
        send(c);
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'h10000};
        send(c);
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 0, 32'hffff0000,
              32'h10000};
        send(c);
        c = '{0, 0, 32'h20000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000};
        send(c);
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h30000};
        send(c);
        c = '{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h80000000, 32'h7fffffff,
              0, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
        send(c);
        c = '{1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1};
        send(c);
        c = '{1, 0, 0, 0, 0, 0, 0, 0, 1, 32'hffffffff, 0, 1};
        send(c);
        c = '{32'h00000003, 32'hfffffffd, 32'h7, 32'h80000001, 32'h7ffffffe, 0,
              32'h12345678, 32'hedcba987, 32'h55555555, 32'haaaaaaaa, 1, 32'hffffffff};
        send(c);

        // pressure: keep offering items while results are held back
        hold_off = 1;
        for (int i = 0; i < 150; i++)
        begin
            foreach (c[k]) c[k] = rand_coord(1);
            send(c);
        end

        for (int i = 0; i < 1250; i++)
        begin
            mode = $urandom_range(0, 9);
            mode = (mode < 4) ? 1 : (mode < 7) ? 0 : (mode < 8) ? 2 : 3;
            foreach (c[k]) c[k] = rand_coord(mode);
            if ($urandom_range(0, 24) == 0)
            begin
                c[6] = c[3];
                c[7] = c[4];
                c[8] = c[5];
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                c[0] = c[3];
                c[1] = c[4];
                c[2] = c[5];
            end
            send(c);
            if ($urandom_range(0, 2) == 0)
            begin
                idle(gap_len());
            end
        end
        points.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[dihedral_angle_from_four_points] OK");
        end
        else
        begin
            $display("[dihedral_angle_from_four_points] ERROR");
        end
        $finish;
    end
endmodule
